// File: src/multistep_integrator_bank_core_assert.svh
// assertion macros used by the checker file
`ifndef MULTISTEP_INTEGRATOR_BANK_CORE_ASSERT_SVH
`define MULTISTEP_INTEGRATOR_BANK_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define MIB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MIB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// checked on the first edge with reset released after a reset edge
`define MIB_ASSERT_POST_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) $past(!(rstn)) && (rstn) |-> (cons)) \
        else $error(msg);

`endif

// File: src/mib_pkg.sv
`default_nettype none

package mib_pkg;

    localparam int NUM_ENTRIES_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int DATA_W   = 32;
    localparam int STEP_W   = 31;
    localparam int IDX_W    = 6;
    localparam int PHASE_W  = 2;
    // weighted sum h3 + 2*h2 + 2*h1 + in
    localparam int SUM_W    = DATA_W + 4;
    // magnitude of the weighted sum is at most 6 * 2^31, split in two halves
    localparam int HALF_W   = 17;
    localparam int MAG_W    = 2 * HALF_W;
    // divide-by-three digit step: remainder plus one half word
    localparam int DIV_IN_W = HALF_W + 2;
    localparam int DIV_Q_W  = DIV_IN_W - 1;
    localparam int DIV3_SHIFT = DIV_IN_W + 1;
    // increment magnitude, clamped at 2^32
    localparam int Q_W      = DATA_W + 1;
    localparam int RES_W    = DATA_W + 3;

    localparam logic [STEP_W-1:0]  SUB_STEP_RESET = 31'd16384;
    localparam logic [PHASE_W-1:0] PHASE_RESET    = 2'd3;
    localparam logic [PHASE_W-1:0] PHASE_MAJOR    = 2'd3;
    // ceil(2^20 / 3), exact quotient for every input below 2^19
    localparam logic [DIV_IN_W-1:0] DIV3_RECIP    = 19'd349526;

    typedef enum logic {
        KIND_INTEGRATE = 1'b0,
        KIND_PHASE     = 1'b1
    } kind_t;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOAD   = 8'b0000_0100,
        ST_MUL    = 8'b0000_1000,
        ST_SCALE  = 8'b0001_0000,
        ST_DIV_HI = 8'b0010_0000,
        ST_DIV_LO = 8'b0100_0000,
        ST_WB     = 8'b1000_0000
    } mib_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] accum;
        logic signed [DATA_W-1:0] hist1;
        logic signed [DATA_W-1:0] hist2;
        logic signed [DATA_W-1:0] hist3;
    } entry_word_t;

    typedef struct packed {
        logic [DIV_Q_W-1:0] quot;
        logic [1:0]         rem;
    } div3_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic signed [DATA_W-1:0] v);
        return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // one digit of a divide by three via reciprocal multiply
    function automatic div3_t div3(input logic [DIV_IN_W-1:0] v);
        logic [2*DIV_IN_W-1:0] prod;
        logic [DIV_IN_W-1:0]   triple;
        logic [DIV_IN_W-1:0]   diff;
        div3_t                 r;
        prod   = (2*DIV_IN_W)'(v) * (2*DIV_IN_W)'(DIV3_RECIP);
        r.quot = prod[2*DIV_IN_W-1:DIV3_SHIFT];
        triple = DIV_IN_W'({r.quot, 1'b0}) + DIV_IN_W'(r.quot);
        diff   = v - triple;
        r.rem  = diff[1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/multistep_integrator_bank_core.sv
// Bank of NUM_ENTRIES fixed-point integrators (signed, FRAC_BITS fraction bits)
// plus a four-phase major/minor step counter. An integrate transaction names an
// entry; on first use the entry loads initial_value with cleared history, then
// (unless bypass) gains sub_step/3 * (h3/2 + h2 + h1 + in/2), rounded to nearest
// with ties away from zero and saturated to 32 bits, and its history shifts.
// A phase transaction returns sub_step with the major/minor flags and advances
// the phase unless bypass is set. One transaction is in work at a time; the
// input is taken again as soon as the previous result sits in the output
// register, even if that result has not yet been taken. An integrate runs a
// read-modify-write of the entry memory around one shared arithmetic path:
// multiply, rounding scale, and a two-digit divide by three. A bypassed
// integrate skips the arithmetic; a phase transaction or an index at or beyond
// NUM_ENTRIES goes straight to writeback, where a stalled output holds it.
// After reset the entry valid bits are cleared by a pass over the valid memory
// with s_ready low; sub_step may be written then.
`default_nettype none

module multistep_integrator_bank_core #(
    parameter int NUM_ENTRIES = mib_pkg::NUM_ENTRIES_DEF,
    parameter int FRAC_BITS   = mib_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sub_step register write
    input  logic                                cfg_wr_en,
    input  logic [mib_pkg::STEP_W-1:0]          cfg_wr_data,
    // input transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic                                s_bypass,
    input  logic [mib_pkg::IDX_W-1:0]           s_entry_index,
    input  logic signed [mib_pkg::DATA_W-1:0]   s_derivative_in,
    input  logic signed [mib_pkg::DATA_W-1:0]   s_initial_value,
    // result transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mib_pkg::DATA_W-1:0]   m_state_value,
    output logic [mib_pkg::STEP_W-1:0]          m_step_size,
    output logic                                m_major_step,
    output logic                                m_minor_step,
    output logic                                m_saturated
);
    import mib_pkg::*;

    localparam int ADDR_W    = addr_bits(NUM_ENTRIES);
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int PROD_W    = STEP_W + HALF_W;
    localparam int FULL_W    = PROD_W + HALF_W + 1;
    localparam int WORD_W    = $bits(entry_word_t);

    // half an lsb of the final quotient, in product units
    localparam logic [FULL_W-1:0] ROUND_BIAS = FULL_W'(3) << FRAC_BITS;
    // a scaled value this large gives an increment of 2^32 or more
    localparam logic [FULL_W-1:0] QUOT_LIMIT = FULL_W'(3) << DATA_W;
    localparam logic [Q_W-1:0]    Q_CLAMP    = Q_W'(1) << DATA_W;
    localparam logic [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

    // control state
    mib_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [STEP_W-1:0]    sub_step_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic                 m_valid_reg;

    // transaction context
    logic [ADDR_W-1:0]        addr_reg;
    logic                     bypass_reg;
    logic signed [DATA_W-1:0] din_reg;
    logic signed [DATA_W-1:0] init_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     major_reg;
    logic                     minor_reg;
    logic                     arith_reg;   // update goes through the adder
    logic                     wr_reg;      // entry gets written back

    // datapath pipeline
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] nh1_reg;
    logic signed [DATA_W-1:0] nh2_reg;
    logic signed [DATA_W-1:0] nh3_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        pp_lo_reg;
    logic [PROD_W-1:0]        pp_hi_reg;
    logic [MAG_W-1:0]         x_reg;
    logic                     big_reg;
    logic [DIV_Q_W-1:0]       qh_reg;
    logic [1:0]               rem_reg;
    logic [Q_W-1:0]           q_reg;

    // output register
    logic signed [DATA_W-1:0] m_state_value_reg;
    logic [STEP_W-1:0]        m_step_size_reg;
    logic                     m_major_step_reg;
    logic                     m_minor_step_reg;
    logic                     m_saturated_reg;

    logic                 in_fire;
    logic                 wb_fire;
    logic                 clr_done;
    logic                 is_clear;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [ADDR_W-1:0]    in_addr;
    logic                 in_range;

    // memory ports
    entry_word_t          rd_word;
    entry_word_t          wr_word;
    logic                 rd_valid;
    logic                 data_wr_en;
    logic                 valid_wr_en;
    logic                 valid_wr_data;
    logic [ADDR_W-1:0]    wr_addr;

    // load stage
    logic signed [DATA_W-1:0] cur_acc;
    logic signed [DATA_W-1:0] cur_h1;
    logic signed [DATA_W-1:0] cur_h2;
    logic signed [DATA_W-1:0] cur_h3;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_abs;

    // scale and divide stages
    logic [FULL_W-1:0]    full_sum;
    logic [FULL_W-1:0]    scaled;
    div3_t                dig_hi;
    div3_t                dig_lo;

    // writeback stage
    logic signed [RES_W-1:0]  acc_ext;
    logic signed [RES_W-1:0]  q_ext;
    logic signed [RES_W-1:0]  res_sum;
    logic                     res_over;
    logic                     res_under;
    logic signed [DATA_W-1:0] res_value;
    logic                     res_sat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign wb_fire  = (state_reg == ST_WB) && (!m_valid_reg || m_ready);
    assign is_clear = (state_reg == ST_CLEAR);
    assign clr_done = (clr_cnt_reg == ADDR_W'(NUM_ENTRIES - 1));

    // entry index to memory address; out-of-range indexes never write memory
    assign idx_ext  = IDX_EXT_W'(s_entry_index);
    assign in_addr  = idx_ext[ADDR_W-1:0];
    assign in_range = (32'(s_entry_index) < 32'(NUM_ENTRIES));

    // ---------------------------------------------------------------- memories
    // data words carry no reset; the valid memory is swept after reset
    assign wr_addr       = is_clear ? clr_cnt_reg : addr_reg;
    assign data_wr_en    = wb_fire && wr_reg;
    assign valid_wr_en   = is_clear || data_wr_en;
    assign valid_wr_data = !is_clear;

    assign wr_word.accum = res_value;
    assign wr_word.hist1 = nh1_reg;
    assign wr_word.hist2 = nh2_reg;
    assign wr_word.hist3 = nh3_reg;

    mib_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_ENTRIES)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (data_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (in_fire),
        .rd_addr (in_addr),
        .rd_data (rd_word)
    );

    mib_ram #(
        .WIDTH (1),
        .DEPTH (NUM_ENTRIES)
    ) u_valid_ram (
        .aclk    (aclk),
        .wr_en   (valid_wr_en),
        .wr_addr (wr_addr),
        .wr_data (valid_wr_data),
        .rd_en   (in_fire),
        .rd_addr (in_addr),
        .rd_data (rd_valid)
    );

    // ------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if ((s_kind == KIND_INTEGRATE) && in_range) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_WB;
                    end
                end
            end
            ST_LOAD:   state_next = bypass_reg ? ST_WB : ST_MUL;
            ST_MUL:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV_HI;
            ST_DIV_HI: state_next = ST_DIV_LO;
            ST_DIV_LO: state_next = ST_WB;
            ST_WB: begin
                if (wb_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            sub_step_reg <= SUB_STEP_RESET;
            phase_reg    <= PHASE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (is_clear) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cfg_wr_en) begin
                sub_step_reg <= cfg_wr_data;
            end
            // phase moves at acceptance; the flags were sampled from the old phase
            if (in_fire && (s_kind == KIND_PHASE) && !s_bypass) begin
                phase_reg <= phase_reg + PHASE_W'(1);
            end
            if (wb_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- load stage
    // a never-used entry reads as initial value with empty history
    assign cur_acc = rd_valid ? rd_word.accum : init_reg;
    assign cur_h1  = rd_valid ? rd_word.hist1 : '0;
    assign cur_h2  = rd_valid ? rd_word.hist2 : '0;
    assign cur_h3  = rd_valid ? rd_word.hist3 : '0;

    // twice the trapezoid-style weighted sum, exact
    assign w_sum = sext_sum(cur_h3) + (sext_sum(cur_h2) <<< 1)
                 + (sext_sum(cur_h1) <<< 1) + sext_sum(din_reg);
    assign w_abs = w_sum[SUM_W-1] ? -w_sum : w_sum;

    // ------------------------------------------------------ scale and divide
    // q = floor((p*m + 3*2^F) / (6*2^F)) = floor(floor((p*m + 3*2^F) / 2^(F+1)) / 3)
    assign full_sum = FULL_W'(pp_lo_reg) + (FULL_W'(pp_hi_reg) << HALF_W) + ROUND_BIAS;
    assign scaled   = full_sum >> (FRAC_BITS + 1);

    // long division by three, one half word per cycle
    assign dig_hi = div3({2'b00, x_reg[MAG_W-1:HALF_W]});
    assign dig_lo = div3({rem_reg, x_reg[HALF_W-1:0]});

    // ------------------------------------------------------- writeback stage
    assign acc_ext = {{(RES_W-DATA_W){acc_reg[DATA_W-1]}}, acc_reg};
    assign q_ext   = {{(RES_W-Q_W){1'b0}}, q_reg};
    assign res_sum = neg_reg ? (acc_ext - q_ext) : (acc_ext + q_ext);

    // anything outside the 32-bit range shows up in the top bits
    assign res_over  = !res_sum[RES_W-1] && (res_sum[RES_W-2:DATA_W-1] != '0);
    assign res_under =  res_sum[RES_W-1] && (res_sum[RES_W-2:DATA_W-1] != '1);

    always_comb begin
        res_value = acc_reg;
        res_sat   = 1'b0;
        if (arith_reg) begin
            res_sat = res_over || res_under;
            if (res_over) begin
                res_value = SAT_MAX;
            end else if (res_under) begin
                res_value = SAT_MIN;
            end else begin
                res_value = res_sum[DATA_W-1:0];
            end
        end
    end

    // ------------------------------------------------------- datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            addr_reg   <= in_addr;
            bypass_reg <= s_bypass;
            din_reg    <= s_derivative_in;
            init_reg   <= s_initial_value;
            acc_reg    <= '0;
            arith_reg  <= 1'b0;
            wr_reg     <= 1'b0;
            if (s_kind == KIND_PHASE) begin
                step_reg  <= sub_step_reg;
                major_reg <= (phase_reg == PHASE_MAJOR);
                minor_reg <= (phase_reg != PHASE_MAJOR);
            end else begin
                step_reg  <= '0;
                major_reg <= 1'b0;
                minor_reg <= 1'b0;
            end
        end

        if (state_reg == ST_LOAD) begin
            acc_reg   <= cur_acc;
            mag_reg   <= w_abs[MAG_W-1:0];
            neg_reg   <= w_sum[SUM_W-1];
            arith_reg <= !bypass_reg;
            // bypass still commits a first-use load
            wr_reg    <= !bypass_reg || !rd_valid;
            if (bypass_reg) begin
                nh1_reg <= cur_h1;
                nh2_reg <= cur_h2;
                nh3_reg <= cur_h3;
            end else begin
                nh1_reg <= din_reg;
                nh2_reg <= cur_h1;
                nh3_reg <= cur_h2;
            end
        end

        if (state_reg == ST_MUL) begin
            pp_lo_reg <= PROD_W'(sub_step_reg) * PROD_W'(mag_reg[HALF_W-1:0]);
            pp_hi_reg <= PROD_W'(sub_step_reg) * PROD_W'(mag_reg[MAG_W-1:HALF_W]);
        end

        if (state_reg == ST_SCALE) begin
            x_reg   <= scaled[MAG_W-1:0];
            big_reg <= (scaled >= QUOT_LIMIT);
        end

        if (state_reg == ST_DIV_HI) begin
            qh_reg  <= dig_hi.quot;
            rem_reg <= dig_hi.rem;
        end

        if (state_reg == ST_DIV_LO) begin
            // a clamped increment of 2^32 always saturates
            q_reg <= big_reg ? Q_CLAMP : Q_W'({qh_reg, dig_lo.quot[HALF_W-1:0]});
        end

        if (wb_fire) begin
            m_state_value_reg <= res_value;
            m_step_size_reg   <= step_reg;
            m_major_step_reg  <= major_reg;
            m_minor_step_reg  <= minor_reg;
            m_saturated_reg   <= res_sat;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_state_value = m_state_value_reg;
    assign m_step_size   = m_step_size_reg;
    assign m_major_step  = m_major_step_reg;
    assign m_minor_step  = m_minor_step_reg;
    assign m_saturated   = m_saturated_reg;

endmodule

`default_nettype wire

// File: src/mib_ram.sv
`default_nettype none

module mib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [mib_pkg::addr_bits(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [mib_pkg::addr_bits(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/mib_checker.sv
`default_nettype none

`include "multistep_integrator_bank_core_assert.svh"

module mib_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [mib_pkg::DATA_W-1:0]   m_state_value,
    input wire logic [mib_pkg::STEP_W-1:0]          m_step_size,
    input wire logic                                m_major_step,
    input wire logic                                m_minor_step,
    input wire logic                                m_saturated
);

    // stalled result stays put
    `MIB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_state_value) && $stable(m_step_size) && $stable(m_saturated) && $stable(m_major_step) && $stable(m_minor_step), "result changed while stalled")

    // clipping only ever lands on a rail, and only on integrate results
    `MIB_ASSERT_IMP(a_sat_rail, aclk, aresetn, m_valid && m_saturated, (m_state_value == 32'sh7fffffff || m_state_value == 32'sh80000000) && !m_major_step && !m_minor_step, "saturated result off the rails")

    // phase results carry exactly one flag and no state, integrate results no step
    `MIB_ASSERT_IMP(a_result_kind, aclk, aresetn, m_valid, (m_major_step || m_minor_step) ? (!(m_major_step && m_minor_step) && m_state_value == '0) : (m_step_size == '0), "result fields mix kinds")

    // clearing pass blocks input and nothing is pending out of reset
    `MIB_ASSERT_POST_RESET(a_reset_quiet, aclk, aresetn, !s_ready && !m_valid, "busy state wrong after reset")

endmodule

bind multistep_integrator_bank_core mib_checker u_mib_checker (.*);

`default_nettype wire
